### src/text_window_console_defines.svh
// ----------------------------------------------------------------------------
// text window console assertion macros
// shared property wrappers for same-cycle and next-cycle checks
// ----------------------------------------------------------------------------
`ifndef TEXT_WINDOW_CONSOLE_DEFINES_SVH
`define TEXT_WINDOW_CONSOLE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TWC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define TWC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/twc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_pkg
// types, codes and widths shared by the text window console modules
// ----------------------------------------------------------------------------
package twc_pkg;

   localparam int SCREEN_COLS_DEF = 80;
   localparam int SCREEN_ROWS_DEF = 25;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int BYTE_W = 8;
   localparam int MODE_W = 2;
   localparam int CELL_W = 16;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;
   localparam int REQ_DW = 32;
   localparam int RSP_DW = 32;

   localparam logic [2:0] REG_WIN_LEFT   = 3'd0;
   localparam logic [2:0] REG_WIN_RIGHT  = 3'd1;
   localparam logic [2:0] REG_WIN_TOP    = 3'd2;
   localparam logic [2:0] REG_WIN_BOTTOM = 3'd3;
   localparam logic [2:0] REG_BLANK_ATTR = 3'd4;

   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUT   = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_SET   = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_INIT   = 3'd0,
      ST_IDLE   = 3'd1,
      ST_EXEC   = 3'd2,
      ST_SCROLL = 3'd3,
      ST_DRAIN  = 3'd4,
      ST_FILL   = 3'd5,
      ST_RESP   = 3'd6
   } state_type;

   // effective window, always at least one cell
   typedef struct packed {
      logic [COL_W-1:0]  left;
      logic [COL_W-1:0]  right;
      logic [ROW_W-1:0]  top;
      logic [ROW_W-1:0]  bottom;
      logic [BYTE_W-1:0] blank_attr;
   } win_type;

endpackage

### src/twc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_ram
// generic single-write single-read memory with registered read data
// ----------------------------------------------------------------------------
module twc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/twc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_csr
// window registers on the apb port and effective window bounds
// ----------------------------------------------------------------------------
module twc_csr
   import twc_pkg::*;
#(
   parameter int SCREEN_COLS = SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output win_type           win
);

   localparam int ColsCap = (SCREEN_COLS > 127) ? 127 : SCREEN_COLS;
   localparam int RowsCap = (SCREEN_ROWS > 31) ? 31 : SCREEN_ROWS;
   localparam logic [COL_W-1:0] ColsLim = COL_W'(ColsCap);
   localparam logic [ROW_W-1:0] RowsLim = ROW_W'(RowsCap);

   logic [COL_W-1:0]  win_left_ff,   win_left_in;
   logic [COL_W-1:0]  win_right_ff,  win_right_in;
   logic [ROW_W-1:0]  win_top_ff,    win_top_in;
   logic [ROW_W-1:0]  win_bottom_ff, win_bottom_in;
   logic [BYTE_W-1:0] blank_attr_ff, blank_attr_in;
   logic              wr_en;
   logic [2:0]        reg_idx;
   logic [COL_W-1:0]  eff_r;
   logic [ROW_W-1:0]  eff_b;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= 7'd0;
         win_right_ff  <= 7'd80;
         win_top_ff    <= 5'd0;
         win_bottom_ff <= 5'd25;
         blank_attr_ff <= 8'd7;
      end else begin
         win_left_ff   <= win_left_in;
         win_right_ff  <= win_right_in;
         win_top_ff    <= win_top_in;
         win_bottom_ff <= win_bottom_in;
         blank_attr_ff <= blank_attr_in;
      end
   end

   always_comb begin
      win_left_in   = win_left_ff;
      win_right_in  = win_right_ff;
      win_top_in    = win_top_ff;
      win_bottom_in = win_bottom_ff;
      blank_attr_in = blank_attr_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_WIN_LEFT:   win_left_in   = csr_pwdata[COL_W-1:0];
            REG_WIN_RIGHT:  win_right_in  = csr_pwdata[COL_W-1:0];
            REG_WIN_TOP:    win_top_in    = csr_pwdata[ROW_W-1:0];
            REG_WIN_BOTTOM: win_bottom_in = csr_pwdata[ROW_W-1:0];
            REG_BLANK_ATTR: blank_attr_in = csr_pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WIN_LEFT:   csr_prdata = CSR_DW'(win_left_ff);
         REG_WIN_RIGHT:  csr_prdata = CSR_DW'(win_right_ff);
         REG_WIN_TOP:    csr_prdata = CSR_DW'(win_top_ff);
         REG_WIN_BOTTOM: csr_prdata = CSR_DW'(win_bottom_ff);
         REG_BLANK_ATTR: csr_prdata = CSR_DW'(blank_attr_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // saturate to the screen, keep at least one cell
   always_comb begin
      eff_r = (win_right_ff > ColsLim) ? ColsLim : win_right_ff;
      if (eff_r == '0) begin
         eff_r = 7'd1;
      end
      eff_b = (win_bottom_ff > RowsLim) ? RowsLim : win_bottom_ff;
      if (eff_b == '0) begin
         eff_b = 5'd1;
      end
      win.right      = eff_r;
      win.bottom     = eff_b;
      win.left       = (win_left_ff > eff_r - 7'd1) ? eff_r - 7'd1 : win_left_ff;
      win.top        = (win_top_ff > eff_b - 5'd1) ? eff_b - 5'd1 : win_top_ff;
      win.blank_attr = blank_attr_ff;
   end

endmodule

### src/twc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_ctrl
// sequencer for put, clear, set and read; walks the cell memory for clear,
// scroll and the post-reset wipe through one address unit
// ----------------------------------------------------------------------------
`include "text_window_console_defines.svh"

module twc_ctrl
   import twc_pkg::*;
#(
   parameter int SCREEN_COLS = SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
   localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,
   input  logic [MODE_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,
   input  win_type           win,
   output logic              ram_we,
   output logic [AW-1:0]     ram_waddr,
   output logic [CELL_W-1:0] ram_wdata,
   output logic              ram_re,
   output logic [AW-1:0]     ram_raddr,
   input  logic [CELL_W-1:0] ram_rdata
);

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [BYTE_W-1:0] char_ff, char_in;
   logic [BYTE_W-1:0] attr_ff, attr_in;
   logic [COL_W-1:0]  rel_col_ff, rel_col_in;
   logic [ROW_W-1:0]  rel_row_ff, rel_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  x_ff, x_in;
   logic [ROW_W-1:0]  y_ff, y_in;
   logic [CELL_W-1:0] fill_ff, fill_in;
   logic              scrolled_ff, scrolled_in;
   logic              rd_hit_ff, rd_hit_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [AW-1:0]     init_cnt_ff, init_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DW-1:0] rsp_data_ff, rsp_data_in;

   logic [COL_W:0]    col_inc;
   logic [ROW_W:0]    row_inc;
   logic              rel_hit;
   logic              x_last;
   logic [COL_W-1:0]  rsp_col;
   logic [ROW_W-1:0]  rsp_row;
   logic [CELL_W-1:0] rsp_cell;

   function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
      return AW'(row) * AW'(SCREEN_COLS) + AW'(col);
   endfunction

   assign col_inc  = {1'b0, cur_col_ff} + 8'd1;
   assign row_inc  = {1'b0, cur_row_ff} + 6'd1;
   assign rel_hit  = (rel_col_ff < win.right - win.left) && (rel_row_ff < win.bottom - win.top);
   assign x_last   = (x_ff == win.right - 7'd1);
   assign rsp_col  = cur_col_ff - win.left;
   assign rsp_row  = cur_row_ff - win.top;
   assign rsp_cell = rd_hit_ff ? ram_rdata : '0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         pend_ff      <= 1'b0;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         pend_ff      <= pend_in;
         init_cnt_ff  <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      char_ff      <= char_in;
      attr_ff      <= attr_in;
      rel_col_ff   <= rel_col_in;
      rel_row_ff   <= rel_row_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      fill_ff      <= fill_in;
      scrolled_ff  <= scrolled_in;
      rd_hit_ff    <= rd_hit_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      char_in      = char_ff;
      attr_in      = attr_ff;
      rel_col_in   = rel_col_ff;
      rel_row_in   = rel_row_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      fill_in      = fill_ff;
      scrolled_in  = scrolled_ff;
      rd_hit_in    = rd_hit_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      init_cnt_in  = init_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_tready   = (state_ff == ST_IDLE);
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = init_cnt_ff;
            if (init_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               init_cnt_in = init_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in     = mode_type'(req_tuser);
               char_in     = req_tdata[7:0];
               attr_in     = req_tdata[15:8];
               rel_col_in  = req_tdata[22:16];
               rel_row_in  = req_tdata[27:23];
               scrolled_in = 1'b0;
               rd_hit_in   = 1'b0;
               // pull a stale cursor back into the window
               if (cur_col_ff < win.left || cur_col_ff >= win.right) begin
                  cur_col_in = win.left;
               end
               if (cur_row_ff < win.top || cur_row_ff >= win.bottom) begin
                  cur_row_in = win.top;
               end
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_RESP;
            unique case (mode_ff)
               MODE_PUT: begin
                  if (char_ff != CHAR_NEWLINE) begin
                     ram_we    = 1'b1;
                     ram_waddr = cell_addr(cur_row_ff, cur_col_ff);
                     ram_wdata = {attr_ff, char_ff};
                  end
                  if (char_ff == CHAR_NEWLINE || col_inc >= {1'b0, win.right}) begin
                     cur_col_in = win.left;
                     x_in       = win.left;
                     if (row_inc >= {1'b0, win.bottom}) begin
                        cur_row_in  = win.bottom - 5'd1;
                        scrolled_in = 1'b1;
                        if (win.top + 5'd1 == win.bottom) begin
                           y_in     = win.bottom - 5'd1;
                           fill_in  = {win.blank_attr, CHAR_SPACE};
                           state_in = ST_FILL;
                        end else begin
                           y_in     = win.top;
                           state_in = ST_SCROLL;
                        end
                     end else begin
                        cur_row_in = row_inc[ROW_W-1:0];
                     end
                  end else begin
                     cur_col_in = col_inc[COL_W-1:0];
                  end
               end
               MODE_CLEAR: begin
                  cur_col_in = win.left;
                  cur_row_in = win.top;
                  x_in       = win.left;
                  y_in       = win.top;
                  fill_in    = {attr_ff, char_ff};
                  state_in   = ST_FILL;
               end
               MODE_SET: begin
                  if (rel_hit) begin
                     cur_col_in = win.left + rel_col_ff;
                     cur_row_in = win.top + rel_row_ff;
                  end
               end
               MODE_READ: begin
                  rd_hit_in = rel_hit;
                  ram_re    = rel_hit;
                  ram_raddr = cell_addr(win.top + rel_row_ff, win.left + rel_col_ff);
               end
               default: ;
            endcase
         end
         ST_SCROLL: begin
            // read the row below, write it back in the following cycle
            ram_re       = 1'b1;
            ram_raddr    = cell_addr(y_ff + 5'd1, x_ff);
            pend_in      = 1'b1;
            pend_addr_in = cell_addr(y_ff, x_ff);
            if (x_last) begin
               x_in = win.left;
               if ({1'b0, y_ff} + 6'd2 == {1'b0, win.bottom}) begin
                  state_in = ST_DRAIN;
               end else begin
                  y_in = y_ff + 5'd1;
               end
            end else begin
               x_in = x_ff + 7'd1;
            end
         end
         ST_DRAIN: begin
            x_in     = win.left;
            y_in     = win.bottom - 5'd1;
            fill_in  = {win.blank_attr, CHAR_SPACE};
            state_in = ST_FILL;
         end
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(y_ff, x_ff);
            ram_wdata = fill_ff;
            if (x_last) begin
               x_in = win.left;
               if (y_ff == win.bottom - 5'd1) begin
                  state_in = ST_RESP;
               end else begin
                  y_in = y_ff + 5'd1;
               end
            end else begin
               x_in = x_ff + 7'd1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, scrolled_ff, rsp_cell, rsp_row, rsp_col};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (pend_ff) begin
         ram_we    = 1'b1;
         ram_waddr = pend_addr_ff;
         ram_wdata = ram_rdata;
      end
   end

   `TWC_ASSERT_NXT(a_accept_exec, clock, reset, req_tvalid && req_tready, state_ff == ST_EXEC, "accepted beat did not enter execute")
   `TWC_ASSERT_IMP(a_pend_scroll, clock, reset, pend_ff, state_ff == ST_SCROLL || state_ff == ST_DRAIN, "scroll write-back outside scroll")
   `TWC_ASSERT_IMP(a_cursor_window, clock, reset, state_ff == ST_RESP, cur_col_ff >= win.left && cur_col_ff < win.right && cur_row_ff >= win.top && cur_row_ff < win.bottom, "cursor outside window at response")
   `TWC_ASSERT_IMP(a_scroll_bottom, clock, reset, state_ff == ST_RESP && scrolled_ff, {1'b0, cur_row_ff} + 6'd1 == {1'b0, win.bottom}, "scroll left cursor off the bottom row")

endmodule

### src/text_window_console.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_window_console
// text window over a cell memory: put, clear, set cursor, read cell
// ----------------------------------------------------------------------------
// an accepted beat passes the execute and response states before rsp_tvalid
// rises, and no new beat is taken until its response is issued; a put past the
// bottom row shifts the window up a row and blanks the bottom row, a clear fills
// the window, one cell per memory cycle. reset: control, cursor and window
// registers reset, then a wipe zeroes the cell memory; no beat is taken until it ends
module text_window_console
   import twc_pkg::*;
#(
   parameter int SCREEN_COLS = SCREEN_COLS_DEF,
   parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // char_code[7:0], attr[15:8], rel_col[22:16], rel_row[27:23]
   input  logic [REQ_DW-1:0] req_tdata,
   // mode[1:0]
   input  logic [MODE_W-1:0] req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // cursor_col[6:0], cursor_row[11:7], read_char[19:12], read_attr[27:20],
   // scrolled[28]
   output logic [RSP_DW-1:0] rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS;
   localparam int AW = $clog2(DEPTH);

   win_type           win;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [CELL_W-1:0] ram_rdata;

   twc_csr #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .win         (win)
   );

   twc_ctrl #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .win        (win),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   twc_ram #(
      .WIDTH (CELL_W),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

### sim/text_window_console_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_window_console_checker
// watches the request, result and register buses of the text window console,
// keeps its own copy of the cell memory, cursor and window registers, works
// out the expected result of every accepted request beat and compares each
// result beat field by field with the oldest expected one
// ----------------------------------------------------------------------------
module text_window_console_checker
   import twc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,
   input  logic [MODE_W-1:0] req_tuser,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_DW-1:0] rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic              csr_pready,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output int                mismatch_count,
   output int                views_pending
);

   localparam int CELLS = SCREEN_COLS_DEF * SCREEN_ROWS_DEF;
   localparam int PRINT_CAP = 100;

   // rel_row, rel_col, attr, char_code from the top bit down
   typedef struct packed {
      logic [ROW_W-1:0]  rel_row;
      logic [COL_W-1:0]  rel_col;
      logic [BYTE_W-1:0] attr;
      logic [BYTE_W-1:0] char_code;
   } console_cmd_type;

   typedef struct packed {
      logic              scrolled;
      logic [BYTE_W-1:0] read_attr;
      logic [BYTE_W-1:0] read_char;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
   } console_view_type;

   logic [CELL_W-1:0] screen [0:CELLS-1];
   int                cur_x;
   int                cur_y;
   logic [COL_W-1:0]  win_left;
   logic [COL_W-1:0]  win_right;
   logic [ROW_W-1:0]  win_top;
   logic [ROW_W-1:0]  win_bottom;
   logic [BYTE_W-1:0] blank_attr;
   int                left_edge;
   int                right_edge;
   int                top_edge;
   int                bottom_edge;
   console_view_type  expected_views [$];

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // clamp the window registers so the window always holds at least one cell
   function automatic void clamp_window();
      right_edge = (win_right > SCREEN_COLS_DEF) ? SCREEN_COLS_DEF : int'(win_right);
      if (right_edge < 1) right_edge = 1;
      left_edge = (win_left > right_edge - 1) ? right_edge - 1 : int'(win_left);
      bottom_edge = (win_bottom > SCREEN_ROWS_DEF) ? SCREEN_ROWS_DEF : int'(win_bottom);
      if (bottom_edge < 1) bottom_edge = 1;
      top_edge = (win_top > bottom_edge - 1) ? bottom_edge - 1 : int'(win_top);
   endfunction

   function automatic void scroll_window();
      for (int y = top_edge; y + 1 < bottom_edge; y++)
         for (int x = left_edge; x < right_edge; x++)
            screen[y * SCREEN_COLS_DEF + x] = screen[(y + 1) * SCREEN_COLS_DEF + x];
      for (int x = left_edge; x < right_edge; x++)
         screen[(bottom_edge - 1) * SCREEN_COLS_DEF + x] = {blank_attr, CHAR_SPACE};
   endfunction

   function automatic logic next_row();
      cur_x = left_edge;
      cur_y++;
      if (cur_y >= bottom_edge) begin
         cur_y = bottom_edge - 1;
         scroll_window();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic console_view_type step_console(input mode_type op,
                                                     input console_cmd_type cmd);
      console_view_type  view;
      logic [CELL_W-1:0] cell_word;
      logic              in_window;
      view = '0;
      clamp_window();
      if (cur_x < left_edge || cur_x >= right_edge) cur_x = left_edge;
      if (cur_y < top_edge || cur_y >= bottom_edge) cur_y = top_edge;
      in_window = (cmd.rel_col < right_edge - left_edge)
                  && (cmd.rel_row < bottom_edge - top_edge);
      case (op)
         MODE_PUT: begin
            if (cmd.char_code == CHAR_NEWLINE) begin
               view.scrolled = next_row();
            end else begin
               screen[cur_y * SCREEN_COLS_DEF + cur_x] = {cmd.attr, cmd.char_code};
               cur_x++;
               if (cur_x >= right_edge) view.scrolled = next_row();
            end
         end
         MODE_CLEAR: begin
            for (int y = top_edge; y < bottom_edge; y++)
               for (int x = left_edge; x < right_edge; x++)
                  screen[y * SCREEN_COLS_DEF + x] = {cmd.attr, cmd.char_code};
            cur_x = left_edge;
            cur_y = top_edge;
         end
         MODE_SET: begin
            if (in_window) begin
               cur_x = left_edge + cmd.rel_col;
               cur_y = top_edge + cmd.rel_row;
            end
         end
         MODE_READ: begin
            if (in_window) begin
               cell_word = screen[(top_edge + cmd.rel_row) * SCREEN_COLS_DEF
                                  + left_edge + cmd.rel_col];
               view.read_char = cell_word[BYTE_W-1:0];
               view.read_attr = cell_word[CELL_W-1:BYTE_W];
            end
         end
         default: ;
      endcase
      view.cursor_col = COL_W'(cur_x - left_edge);
      view.cursor_row = ROW_W'(cur_y - top_edge);
      return view;
   endfunction

   always @(posedge clock) begin
      console_view_type got;
      console_view_type want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) screen[i] = '0;
         win_left = '0;
         win_right = COL_W'(SCREEN_COLS_DEF);
         win_top = '0;
         win_bottom = ROW_W'(SCREEN_ROWS_DEF);
         blank_attr = 8'h07;
         cur_x = 0;
         cur_y = 0;
         expected_views.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_AW-1:2])
               REG_WIN_LEFT:   win_left = csr_pwdata[COL_W-1:0];
               REG_WIN_RIGHT:  win_right = csr_pwdata[COL_W-1:0];
               REG_WIN_TOP:    win_top = csr_pwdata[ROW_W-1:0];
               REG_WIN_BOTTOM: win_bottom = csr_pwdata[ROW_W-1:0];
               REG_BLANK_ATTR: blank_attr = csr_pwdata[BYTE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_views.push_back(step_console(mode_type'(req_tuser),
                                                  console_cmd_type'(req_tdata[27:0])));
         if (rsp_tvalid && rsp_tready) begin
            got = console_view_type'(rsp_tdata[28:0]);
            if (expected_views.size() == 0) begin
               report_mismatch("result beat with nothing expected", rsp_tdata, 0);
            end else begin
               want = expected_views.pop_front();
               if (got.cursor_col != want.cursor_col)
                  report_mismatch("cursor_col", got.cursor_col, want.cursor_col);
               if (got.cursor_row != want.cursor_row)
                  report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
               if (got.read_char != want.read_char)
                  report_mismatch("read_char", got.read_char, want.read_char);
               if (got.read_attr != want.read_attr)
                  report_mismatch("read_attr", got.read_attr, want.read_attr);
               if (got.scrolled != want.scrolled)
                  report_mismatch("scrolled", got.scrolled, want.scrolled);
            end
         end
      end
      views_pending = expected_views.size();
   end

endmodule

### sim/text_window_console_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_window_console_tb
// drives the text window console with a directed opening (edge characters,
// wraps, scrolls, sets and reads outside the window, clears) and then with
// random commands under a series of window settings, odd and extreme ones
// included; both stream sides idle at random; a checker predicts every
// result beat and this module gives the verdict
// ----------------------------------------------------------------------------
module text_window_console_tb;
   import twc_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES = SCREEN_COLS_DEF * SCREEN_ROWS_DEF + 64;
   localparam int TAIL_CYCLES = 16;
   localparam int RANDOM_ITEMS = 1050;
   localparam int PHASE_ITEMS = 70;
   localparam logic [2:0] REG_UNUSED_LO = 3'd5;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata;
   logic [MODE_W-1:0] req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int send_idle_pct = 13;
   int recv_idle_pct = 82;
   int random_sent;
   int quiet_cycles;
   int win_w;
   int win_h;
   int mismatch_count;
   int views_pending;

   text_window_console dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   text_window_console_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .views_pending  (views_pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** text_window_console: FAILED **");
         $finish;
      end
   end

   task automatic send_beat(input mode_type op, input logic [7:0] ch, input logic [7:0] at,
                            input logic [6:0] rc, input logic [4:0] rr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, rr, rc, at, ch};
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [CSR_DW-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   // block is idle once every result is back and any trailing scroll is done
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (views_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic win_type pick_window(input int phase);
      win_type cfg;
      int      span;
      cfg.blank_attr = BYTE_W'($urandom_range(255));
      case (phase)
         0: cfg = '{left: 7'd10, right: 7'd30, top: 5'd5, bottom: 5'd10, blank_attr: 8'h00};
         1: cfg = '{left: 7'd79, right: 7'd80, top: 5'd24, bottom: 5'd25, blank_attr: 8'hFF};
         2: cfg = '{left: 7'd0, right: 7'd80, top: 5'd12, bottom: 5'd13, blank_attr: 8'h5A};
         3: cfg = '{left: 7'd50, right: 7'd20, top: 5'd20, bottom: 5'd3, blank_attr: 8'h3C};
         4: cfg = '{left: 7'd0, right: 7'd0, top: 5'd0, bottom: 5'd0, blank_attr: 8'h81};
         5: cfg = '{left: 7'd127, right: 7'd127, top: 5'd31, bottom: 5'd31, blank_attr: 8'hC3};
         6: cfg = '{left: 7'd0, right: 7'd80, top: 5'd0, bottom: 5'd25, blank_attr: 8'hE7};
         default: begin
            if ($urandom_range(3) == 0) begin
               cfg.left = COL_W'($urandom_range(127));
               cfg.right = COL_W'($urandom_range(127));
               cfg.top = ROW_W'($urandom_range(31));
               cfg.bottom = ROW_W'($urandom_range(31));
            end else begin
               cfg.left = COL_W'($urandom_range(75));
               span = 1 + $urandom_range(8);
               cfg.right = COL_W'((cfg.left + span > SCREEN_COLS_DEF) ? SCREEN_COLS_DEF
                                                                      : cfg.left + span);
               cfg.top = ROW_W'($urandom_range(23));
               span = 1 + $urandom_range(4);
               cfg.bottom = ROW_W'((cfg.top + span > SCREEN_ROWS_DEF) ? SCREEN_ROWS_DEF
                                                                      : cfg.top + span);
            end
         end
      endcase
      return cfg;
   endfunction

   task automatic apply_window(input win_type cfg);
      int r;
      int l;
      int b;
      int t;
      csr_write(REG_WIN_LEFT, CSR_DW'(cfg.left));
      csr_write(REG_WIN_RIGHT, CSR_DW'(cfg.right));
      csr_write(REG_WIN_TOP, CSR_DW'(cfg.top));
      csr_write(REG_WIN_BOTTOM, CSR_DW'(cfg.bottom));
      csr_write(REG_BLANK_ATTR, CSR_DW'(cfg.blank_attr));
      csr_write(REG_UNUSED_LO, $urandom);
      csr_write(REG_UNUSED_HI, $urandom);
      r = (cfg.right > SCREEN_COLS_DEF) ? SCREEN_COLS_DEF : int'(cfg.right);
      if (r < 1) r = 1;
      l = (cfg.left > r - 1) ? r - 1 : int'(cfg.left);
      b = (cfg.bottom > SCREEN_ROWS_DEF) ? SCREEN_ROWS_DEF : int'(cfg.bottom);
      if (b < 1) b = 1;
      t = (cfg.top > b - 1) ? b - 1 : int'(cfg.top);
      win_w = r - l;
      win_h = b - t;
   endtask

   task automatic send_random_beat();
      int         pick;
      mode_type   op;
      logic [7:0] ch;
      logic [7:0] at;
      logic [6:0] rc;
      logic [4:0] rr;
      pick = $urandom_range(99);
      ch = 8'($urandom_range(255));
      at = 8'($urandom_range(255));
      // mostly aim set and read inside the window
      if ($urandom_range(99) < 80) begin
         rc = 7'($urandom_range(win_w - 1));
         rr = 5'($urandom_range(win_h - 1));
      end else begin
         rc = 7'($urandom_range(127));
         rr = 5'($urandom_range(31));
      end
      if (pick < 58) begin
         op = MODE_PUT;
         if ($urandom_range(99) < 12) ch = CHAR_NEWLINE;
      end else if (pick < 61) begin
         op = MODE_CLEAR;
      end else if (pick < 76) begin
         op = MODE_SET;
      end else begin
         op = MODE_READ;
      end
      send_beat(op, ch, at, rc, rr);
   endtask

   initial begin
      int phase;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_PUT;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      random_sent = 0;
      win_w = SCREEN_COLS_DEF;
      win_h = SCREEN_ROWS_DEF;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening on the full-screen window left by reset
      send_beat(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd0);
      send_beat(MODE_PUT, 8'h41, 8'h1F, 7'd0, 5'd0);
      send_beat(MODE_PUT, 8'h00, 8'h00, 7'd127, 5'd31);
      send_beat(MODE_PUT, 8'hFF, 8'hFF, 7'd0, 5'd0);
      send_beat(MODE_PUT, CHAR_NEWLINE, 8'h55, 7'd0, 5'd0);
      send_beat(MODE_READ, 8'h00, 8'h00, 7'd2, 5'd0);
      send_beat(MODE_SET, 8'h00, 8'h00, 7'd79, 5'd24);
      send_beat(MODE_PUT, 8'h7E, 8'h70, 7'd0, 5'd0);
      send_beat(MODE_READ, 8'h00, 8'h00, 7'd79, 5'd23);
      send_beat(MODE_READ, 8'h00, 8'h00, 7'd0, 5'd24);
      send_beat(MODE_SET, 8'h00, 8'h00, 7'd80, 5'd0);
      send_beat(MODE_SET, 8'h00, 8'h00, 7'd0, 5'd25);
      send_beat(MODE_SET, 8'h00, 8'h00, 7'd127, 5'd31);
      send_beat(MODE_READ, 8'hFF, 8'hFF, 7'd80, 5'd0);
      send_beat(MODE_READ, 8'h00, 8'h00, 7'd127, 5'd31);
      send_beat(MODE_SET, 8'h00, 8'h00, 7'd10, 5'd24);
      send_beat(MODE_PUT, CHAR_NEWLINE, 8'h00, 7'd0, 5'd0);
      send_beat(MODE_CLEAR, CHAR_NEWLINE, 8'hAA, 7'd0, 5'd0);
      send_beat(MODE_READ, 8'h00, 8'h00, 7'd40, 5'd12);
      send_beat(MODE_SET, 8'h00, 8'h00, 7'd0, 5'd24);
      send_beat(MODE_PUT, 8'h5A, 8'h0F, 7'd0, 5'd0);
      send_beat(MODE_CLEAR, CHAR_SPACE, 8'h07, 7'd0, 5'd0);

      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         wait_drained();
         apply_window(pick_window(phase));
         repeat (PHASE_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
               send_idle_pct = 13;
               recv_idle_pct = 82;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
               send_idle_pct = 82;
               recv_idle_pct = 13;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            send_random_beat();
            random_sent++;
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (views_pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && views_pending == 0) begin
         $display("** text_window_console: PASSED **");
      end else begin
         $display("** text_window_console: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/twc_pkg.sv
src/twc_ram.sv
src/twc_csr.sv
src/twc_ctrl.sv
src/text_window_console.sv
sim/text_window_console_checker.sv
sim/text_window_console_tb.sv
